// ----- sv/tlgs_pkg.sv -----
package tlgs_pkg;

  localparam int CFG_DW    = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_ROWS = 1'd1;

  localparam logic [8:0] COLS_RESET = 9'd256;
  localparam logic [7:0] ROWS_RESET = 8'd128;
  localparam int         MIN_SIZE   = 3;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_ADVANCE = 2'd1,
    MODE_READ    = 2'd2
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] row;
    logic [7:0] col;
    logic       cell_in;
  } in_item_t;

  typedef struct packed {
    logic cell_out;
    logic advanced;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_ADV_FIRST,
    ST_ADV_PRIME,
    ST_ADV_ROW
  } state_e;

endpackage

// ----- sv/toroidal_life_generation_step_top.sv -----
// Channel   Handshake            Payload              Notes
// item in   start_i / busy_o     item_i (in_item_t)   taken when start_i & !busy_o
// result    done_o               result_o (out_item_t) one-cycle strobe, no back-pressure
// config    cfg_we_i             cfg_idx_i, cfg_data_i written at once, no read-back
//
// Cell write: row read, then row write-back. Cell read: row read, then the result register.
// Generation step: one row-wide neighbour unit, fed by the single read port of the grid RAM,
// updates one row per cycle in place.
// After reset a clearing pass zeroes the grid, one row a cycle, all MAX_ROWS rows, with busy_o high.
// Results leave through an output register, so busy_o drops in the cycle the result is shown.
module toroidal_life_generation_step_top #(
  parameter int MAX_COLS = 256,
  parameter int MAX_ROWS = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  tlgs_pkg::in_item_t                  item_i,
  output logic                                done_o,
  output tlgs_pkg::out_item_t                 result_o,
  input  logic                                cfg_we_i,
  input  logic [tlgs_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [tlgs_pkg::CFG_DW-1:0]         cfg_data_i
);

  localparam int RowAW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ColAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ColCW = $clog2(MAX_COLS + 1);
  localparam int RowCW = $clog2(MAX_ROWS + 1);
  localparam int CcW   = (ColCW > 9) ? ColCW : 9;
  localparam int RcW   = (RowCW > 8) ? RowCW : 8;

  // config
  logic [8:0] cols_q;
  logic [7:0] rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= tlgs_pkg::COLS_RESET;
      rows_q <= tlgs_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        tlgs_pkg::CFG_ACTIVE_COLS: cols_q <= cfg_data_i[8:0];
        tlgs_pkg::CFG_ACTIVE_ROWS: rows_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // clamped sizes
  logic [CcW-1:0]   cols_ext;
  logic [RcW-1:0]   rows_ext;
  logic [ColCW-1:0] nc;
  logic [RowCW-1:0] nr;
  logic [ColAW-1:0] nc_m1;
  logic [RowAW-1:0] nr_m1;

  always_comb begin
    cols_ext = CcW'(cols_q);
    rows_ext = RcW'(rows_q);
    if (cols_ext < CcW'(tlgs_pkg::MIN_SIZE)) begin
      nc = ColCW'(tlgs_pkg::MIN_SIZE);
    end else if (cols_ext > CcW'(MAX_COLS)) begin
      nc = ColCW'(MAX_COLS);
    end else begin
      nc = ColCW'(cols_ext);
    end
    if (rows_ext < RcW'(tlgs_pkg::MIN_SIZE)) begin
      nr = RowCW'(tlgs_pkg::MIN_SIZE);
    end else if (rows_ext > RcW'(MAX_ROWS)) begin
      nr = RowCW'(MAX_ROWS);
    end else begin
      nr = RowCW'(rows_ext);
    end
    nc_m1 = ColAW'(nc - ColCW'(1));
    nr_m1 = RowAW'(nr - RowCW'(1));
  end

  // grid RAM: one row per word
  logic [MAX_COLS-1:0] grid_mem [MAX_ROWS];
  logic                mem_we;
  logic [RowAW-1:0]    mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [RowAW-1:0]    mem_raddr;
  logic [MAX_COLS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= grid_mem[mem_raddr];
  end

  // sequencer
  tlgs_pkg::state_e    state_q, state_d;
  logic [RowAW-1:0]    y_q, y_d;
  logic                done_q, done_d;
  tlgs_pkg::out_item_t res_q, res_d;
  logic [RowAW-1:0]    row_q, row_d;
  logic [ColAW-1:0]    col_q, col_d;
  logic                bit_q, bit_d;
  logic                inside_q, inside_d;
  logic [MAX_COLS-1:0] up_q, up_d;
  logic [MAX_COLS-1:0] cur_q, cur_d;
  logic [MAX_COLS-1:0] first_q, first_d;
  logic [MAX_COLS-1:0] down;
  logic [MAX_COLS-1:0] next_row;
  logic                accept;
  logic                last_row;

  assign accept   = start_i && (state_q == tlgs_pkg::ST_IDLE);
  assign last_row = (y_q == nr_m1);
  assign down     = last_row ? first_q : rd_q;

  // row-wide neighbour count and B3/S23 update
  logic [ColAW-1:0] li;
  logic [ColAW-1:0] ri;
  logic [3:0]       cnt;

  always_comb begin
    li       = '0;
    ri       = '0;
    cnt      = '0;
    next_row = cur_q;
    for (int x = 0; x < MAX_COLS; x++) begin
      li  = (x == 0) ? nc_m1 : ColAW'(x - 1);
      ri  = ((x == MAX_COLS - 1) || (ColCW'(x + 1) == nc)) ? '0 : ColAW'(x + 1);
      cnt = 4'(up_q[li]) + 4'(up_q[x]) + 4'(up_q[ri])
          + 4'(cur_q[li]) + 4'(cur_q[ri])
          + 4'(down[li]) + 4'(down[x]) + 4'(down[ri]);
      if (ColCW'(x) < nc) begin
        next_row[x] = (cnt == tlgs_pkg::BIRTH_COUNT) ||
                      (cur_q[x] && (cnt == tlgs_pkg::SURVIVE_COUNT));
      end
    end
  end

  always_comb begin
    state_d   = state_q;
    y_d       = y_q;
    done_d    = 1'b0;
    res_d     = '0;
    row_d     = row_q;
    col_d     = col_q;
    bit_d     = bit_q;
    inside_d  = inside_q;
    up_d      = up_q;
    cur_d     = cur_q;
    first_d   = first_q;
    mem_we    = 1'b0;
    mem_waddr = y_q;
    mem_wdata = next_row;
    mem_raddr = y_q;
    case (state_q)
      tlgs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        y_d       = RowAW'(y_q + RowAW'(1));
        if (y_q == RowAW'(MAX_ROWS - 1)) begin
          y_d     = '0;
          state_d = tlgs_pkg::ST_IDLE;
        end
      end
      tlgs_pkg::ST_IDLE: begin
        if (accept) begin
          row_d     = RowAW'(item_i.row);
          col_d     = ColAW'(item_i.col);
          bit_d     = item_i.cell_in;
          inside_d  = (int'(item_i.row) < MAX_ROWS) && (int'(item_i.col) < MAX_COLS);
          mem_raddr = RowAW'(item_i.row);
          case (item_i.mode)
            tlgs_pkg::MODE_WRITE:   state_d = tlgs_pkg::ST_WRITE;
            tlgs_pkg::MODE_READ:    state_d = tlgs_pkg::ST_READ;
            tlgs_pkg::MODE_ADVANCE: begin
              mem_raddr = nr_m1;
              state_d   = tlgs_pkg::ST_ADV_FIRST;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      tlgs_pkg::ST_READ: begin
        done_d         = 1'b1;
        res_d.cell_out = inside_q && rd_q[col_q];
        state_d        = tlgs_pkg::ST_IDLE;
      end
      tlgs_pkg::ST_WRITE: begin
        mem_we         = inside_q;
        mem_waddr      = row_q;
        mem_wdata      = rd_q;
        mem_wdata[col_q] = bit_q;
        done_d         = 1'b1;
        state_d        = tlgs_pkg::ST_IDLE;
      end
      tlgs_pkg::ST_ADV_FIRST: begin
        up_d      = rd_q;
        mem_raddr = '0;
        state_d   = tlgs_pkg::ST_ADV_PRIME;
      end
      tlgs_pkg::ST_ADV_PRIME: begin
        cur_d     = rd_q;
        first_d   = rd_q;
        mem_raddr = RowAW'(1);
        y_d       = '0;
        state_d   = tlgs_pkg::ST_ADV_ROW;
      end
      tlgs_pkg::ST_ADV_ROW: begin
        mem_we    = 1'b1;
        mem_waddr = y_q;
        mem_wdata = next_row;
        mem_raddr = RowAW'(y_q + RowAW'(2));
        up_d      = cur_q;
        cur_d     = down;
        y_d       = RowAW'(y_q + RowAW'(1));
        if (last_row) begin
          y_d            = '0;
          done_d         = 1'b1;
          res_d.advanced = 1'b1;
          state_d        = tlgs_pkg::ST_IDLE;
        end
      end
      default: state_d = tlgs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tlgs_pkg::ST_CLEAR;
      y_q     <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      y_q     <= y_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q    <= res_d;
    row_q    <= row_d;
    col_q    <= col_d;
    bit_q    <= bit_d;
    inside_q <= inside_d;
    up_q     <= up_d;
    cur_q    <= cur_d;
    first_q  <= first_d;
  end

  assign busy_o   = (state_q != tlgs_pkg::ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule
